// ===== design/cbts_pkg.sv =====
// Shared constants, state type and timing word packing for the CAN bit timing search.
package cbts_pkg;

	localparam int CLK_W    = 27;
	localparam int BAUD_W   = 20;
	localparam int DIV_MAX  = 15;
	localparam int Q_MAX    = 32;
	localparam int SEG_MIN  = 3;
	localparam int SEG_MAX  = 17;
	localparam int PRE_W    = 4;
	localparam int WORD_W   = 15;
	localparam int QM1_W    = 5;
	localparam int SEG_W    = 5;
	localparam int CNT_W    = $clog2(CLK_W);
	localparam int QD_W     = $clog2(Q_MAX * (DIV_MAX + 1) + 1);
	localparam int PROD_W   = $clog2(SEG_MAX * Q_MAX * (DIV_MAX + 1) + 1);
	localparam logic [CLK_W-1:0] CLK_RATE_RST = CLK_W'(48000000);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SEARCH,
		ST_DONE
	} cbts_state_t;

	// Pack quanta-1, sjw, seg1 and seg2 from the winning segment count.
	function automatic logic [WORD_W-1:0] timing_pack(input logic [QM1_W-1:0] qm1,
		input logic [SEG_W-1:0] segs);
		logic [SEG_W-1:0] rest;
		logic [SEG_W-1:0] s1;
		logic [SEG_W-1:0] s2;
		logic [1:0]       sjw;
		rest = segs - SEG_W'(SEG_MIN);
		s1   = rest >> 1;
		s2   = rest - s1;
		sjw  = (s1 > SEG_W'(3)) ? 2'd3 : s1[1:0];
		return {s2[2:0], s1[3:0], sjw, 1'b0, qm1};
	endfunction

endpackage

// ===== design/cbts_if.sv =====
// Valid/ready channel interfaces for request, result and configuration transactions.
interface cbts_req_if import cbts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BAUD_W-1:0] bit_rate;
	modport source (output valid, output bit_rate, input ready);
	modport sink   (input valid, input bit_rate, output ready);
endinterface

interface cbts_rsp_if import cbts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [PRE_W-1:0]  prescaler_div;
	logic [WORD_W-1:0] timing_word;
	modport source (output valid, output found, output prescaler_div, output timing_word,
		input ready);
	modport sink   (input valid, input found, input prescaler_div, input timing_word,
		output ready);
endinterface

interface cbts_cfg_if import cbts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CLK_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cbts_divider.sv =====
// Restoring divider, one quotient bit per cycle, for clocks per bit.
module cbts_divider import cbts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CLK_W-1:0]  dividend,
	input  logic [BAUD_W-1:0] divisor,
	output logic              done,
	output logic [CLK_W-1:0]  quotient
);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CLK_W-1:0]  dvd_q;
	logic [BAUD_W-1:0] dvs_q;
	logic [BAUD_W-1:0] rem_q;
	logic [BAUD_W:0]   rem_shift;
	logic [BAUD_W:0]   rem_diff;
	logic              ge;

	assign rem_shift = {rem_q, dvd_q[CLK_W-1]};
	assign ge        = rem_shift >= {1'b0, dvs_q};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(CLK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract where it fits
			dvd_q <= {dvd_q[CLK_W-2:0], ge};
			rem_q <= ge ? rem_diff[BAUD_W-1:0] : rem_shift[BAUD_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== design/can_bit_timing_search.sv =====
// CAN bit timing search top level: divider, search sequencer and result register.
// Sequence: a zero bit rate gives its result in the cycle after the request transaction;
// otherwise the division runs, then one compare per tried triple (up to 7680 triples)
// and then the result. One request at a time.
// Throughput is set by the bit-serial divider and the one-compare-per-cycle search.
// Reset: asynchronous, active low; idles ready, clock rate register back to 48 MHz.
module can_bit_timing_search import cbts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cbts_req_if.sink  req,
	cbts_rsp_if.source rsp,
	cbts_cfg_if.sink  cfg
);

	cbts_state_t state_q, state_nxt;

	logic [CLK_W-1:0]  clk_rate_q;
	logic              div_start;
	logic              div_done;
	logic [CLK_W-1:0]  quotient;
	logic              quo_ok;
	logic              req_acc;

	// Search registers: cpb to match, prescaler, quanta-1, segments, q*(d+1), product
	logic [PROD_W-1:0] cpb_q;
	logic [PRE_W-1:0]  d_q;
	logic [QM1_W-1:0]  qm1_q;
	logic [SEG_W-1:0]  s_q;
	logic [QD_W-1:0]   qd_q;
	logic [PROD_W-1:0] prod_q;

	logic              found_q;
	logic [PRE_W-1:0]  pre_q;
	logic [WORD_W-1:0] word_q;

	logic              hit;
	logic              s_last;
	logic              q_last;
	logic              d_last;
	logic [QD_W-1:0]   qd_q_step;
	logic [QD_W-1:0]   qd_d_step;
	logic [PROD_W-1:0] qd_q_ext;
	logic [PROD_W-1:0] qd_d_ext;

	// Configuration register: always ready; the user must write it only while idle, the block does not enforce this
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_rate_q <= CLK_RATE_RST;
		end else if (cfg.valid) begin
			clk_rate_q <= cfg.data;
		end
	end

	assign req_acc = req.valid && req.ready;

	cbts_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clk_rate_q),
		.divisor  (req.bit_rate),
		.done     (div_done),
		.quotient (quotient)
	);

	// A clocks-per-bit value beyond the largest product, or zero, never matches
	assign quo_ok = (quotient[CLK_W-1:PROD_W] == '0) && (quotient != '0);

	assign hit    = (prod_q == cpb_q);
	assign s_last = (s_q == SEG_W'(SEG_MAX));
	assign q_last = (qm1_q == QM1_W'(Q_MAX - 1));
	assign d_last = (d_q == PRE_W'(DIV_MAX));

	// Next quanta: add (d+1); next prescaler: quanta back to 1, so q*(d+1) = d+2
	assign qd_q_step = qd_q + QD_W'(d_q) + QD_W'(1);
	assign qd_d_step = QD_W'(d_q) + QD_W'(2);
	assign qd_q_ext  = PROD_W'(qd_q_step);
	assign qd_d_ext  = PROD_W'(qd_d_step);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_nxt = (req.bit_rate == '0) ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_nxt = quo_ok ? ST_SEARCH : ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (hit || (s_last && q_last && d_last)) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp.ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				div_start = req.valid && (req.bit_rate != '0);
			end
			ST_DIV:    ;
			ST_SEARCH: ;
			ST_DONE: begin
				rsp.valid = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Search datapath: one compare per cycle, segments innermost
	always_ff @(posedge clk) begin
		if (req_acc) begin
			// clear the result: holds for zero rate and for no match
			found_q <= 1'b0;
			pre_q   <= '0;
			word_q  <= '0;
		end
		if (state_q == ST_DIV && div_done) begin
			cpb_q  <= quotient[PROD_W-1:0];
			d_q    <= '0;
			qm1_q  <= '0;
			s_q    <= SEG_W'(SEG_MIN);
			qd_q   <= QD_W'(1);
			prod_q <= PROD_W'(SEG_MIN);
		end else if (state_q == ST_SEARCH) begin
			if (hit) begin
				found_q <= 1'b1;
				pre_q   <= d_q;
				word_q  <= timing_pack(qm1_q, s_q);
			end else if (!s_last) begin
				s_q    <= s_q + 1'b1;
				prod_q <= prod_q + PROD_W'(qd_q);
			end else if (!q_last) begin
				// advance quanta, segments back to the minimum
				s_q    <= SEG_W'(SEG_MIN);
				qm1_q  <= qm1_q + 1'b1;
				qd_q   <= qd_q_step;
				prod_q <= qd_q_ext + (qd_q_ext << 1);
			end else if (!d_last) begin
				// advance prescaler, quanta and segments back to the start
				s_q    <= SEG_W'(SEG_MIN);
				qm1_q  <= '0;
				d_q    <= d_q + 1'b1;
				qd_q   <= qd_d_step;
				prod_q <= qd_d_ext + (qd_d_ext << 1);
			end
		end
	end

	assign rsp.found         = found_q;
	assign rsp.prescaler_div = pre_q;
	assign rsp.timing_word   = word_q;

endmodule

// ===== tb/sv/timing_checker.sv =====
// Scoreboard that predicts and checks every bit timing result of the search block.
module timing_checker import cbts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	cbts_req_if         req,
	cbts_rsp_if         rsp,
	cbts_cfg_if         cfg,
	output int unsigned mismatch_count,
	output int unsigned awaited_count,
	output int unsigned result_count,
	output int unsigned exact_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PRESCALE_TOP = 15;
	localparam int unsigned QUANTA_TOP   = 32;
	localparam int unsigned SEGS_LOW     = 3;
	localparam int unsigned SEGS_TOP     = 17;
	localparam int unsigned SJW_TOP      = 3;

	typedef struct packed {
		logic              found;
		logic [PRE_W-1:0]  prescaler;
		logic [WORD_W-1:0] word;
	} bit_timing_t;

	bit_timing_t      awaited_timing[$];
	logic [CLK_W-1:0] clock_hz;

	// First exact split of clocks per bit into divider, quanta and segments.
	function automatic bit_timing_t find_bit_timing(input logic [CLK_W-1:0] hz,
		input logic [BAUD_W-1:0] rate);
		bit_timing_t t;
		int unsigned per_bit;
		int unsigned rest;
		int unsigned s1;
		int unsigned s2;
		int unsigned sjw;
		t = '0;
		if (rate == '0)
			return t;
		per_bit = hz / rate;
		for (int unsigned d = 0; d <= PRESCALE_TOP; d++)
			for (int unsigned q = 1; q <= QUANTA_TOP; q++)
				for (int unsigned s = SEGS_LOW; s <= SEGS_TOP; s++)
					if (per_bit == s * q * (d + 1)) begin
						rest = s - SEGS_LOW;
						s1   = rest / 2;
						s2   = rest - s1;
						sjw  = (s1 > SJW_TOP) ? SJW_TOP : s1;
						t.found     = 1'b1;
						t.prescaler = PRE_W'(d);
						t.word      = {3'(s2), 4'(s1), 2'(sjw), 6'(q - 1)};
						return t;
					end
		return t;
	endfunction

	function automatic bit field_differs(input string field, input int unsigned want,
		input int unsigned got);
		if (want == got)
			return 1'b0;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit_timing_t want;
		int unsigned bad;
		if (!arst_n) begin
			clock_hz <= 27'd48_000_000;
			awaited_timing.delete();
			mismatch_count <= 0;
			awaited_count  <= 0;
			result_count   <= 0;
			exact_count    <= 0;
		end else begin
			bad = 0;
			// retire the oldest expectation first, it belongs to an earlier request
			if (rsp.valid && rsp.ready) begin
				result_count <= result_count + 1;
				if (awaited_timing.size() == 0) begin
					$display("%0t: timing result with no request outstanding, actual %0d/%0d/%0d",
						$time, rsp.found, rsp.prescaler_div, rsp.timing_word);
					bad++;
				end else begin
					want = awaited_timing.pop_front();
					if (want.found)
						exact_count <= exact_count + 1;
					bad += field_differs("found", want.found, rsp.found);
					bad += field_differs("prescaler_div", want.prescaler, rsp.prescaler_div);
					bad += field_differs("timing_word", want.word, rsp.timing_word);
				end
			end
			if (req.valid && req.ready)
				awaited_timing.push_back(find_bit_timing(clock_hz, req.bit_rate));
			if (cfg.valid && cfg.ready)
				clock_hz <= cfg.data;
			mismatch_count <= mismatch_count + bad;
			awaited_count  <= awaited_timing.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the bit timing search bench: clock, reset, request and configuration stimulus.
module testbench import cbts_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n;

	cbts_req_if req_ch ();
	cbts_rsp_if rsp_ch ();
	cbts_cfg_if cfg_ch ();

	int unsigned mismatch_count;
	int unsigned awaited_count;
	int unsigned result_count;
	int unsigned exact_count;

	// what the bench believes the clock rate register holds
	logic [CLK_W-1:0] clock_setting;
	// no gaps and no stalls while set
	bit               steady;
	int unsigned      request_count;
	int unsigned      setting_count;

	// Rates at the reset clock of 48 MHz: zero, the field extremes, the common bus rates,
	// a rate with no exact split, the widest quanta with the longest segment, the
	// shortest segment, and one that only the largest prescaler can reach.
	localparam logic [BAUD_W-1:0] RESET_CLOCK_RATES [13] = '{
		20'd0, 20'd1, 20'hFFFFF, 20'd1_000_000, 20'd500_000, 20'd250_000, 20'd125_000,
		20'd100_000, 20'd88_235, 20'd516_129, 20'd5_692, 20'd1_000, 20'd999_999
	};

	always #10 clk = ~clk;

	can_bit_timing_search uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	timing_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.cfg            (cfg_ch),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count),
		.result_count   (result_count),
		.exact_count    (exact_count)
	);

	// Mostly back to back, sometimes a short pause, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 120);
	endfunction

	// Rate that lands on the wanted clocks per bit at the current clock, when one exists.
	function automatic logic [BAUD_W-1:0] rate_for(input int unsigned per_bit);
		int unsigned rate;
		rate = clock_setting / per_bit;
		if (rate == 0)
			rate = 1;
		if (rate > 20'hFFFFF)
			rate = 20'hFFFFF;
		return BAUD_W'(rate);
	endfunction

	// Offer one rate; hold valid high across a zero gap so it is never dropped and raised
	// again in the same step.
	task automatic send_rate(input logic [BAUD_W-1:0] rate);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.bit_rate <= rate;
		do @(posedge clk); while (!req_ch.ready);
		request_count++;
	endtask

	// Drop the request and wait until the checker has seen every result come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_count != 0);
	endtask

	task automatic write_clock(input logic [CLK_W-1:0] hz);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= hz;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid  <= 1'b0;
		clock_setting = hz;
		setting_count++;
	endtask

	// Mostly rates built from a real divider/quanta/segment triple, so that the search
	// stops at every depth; some of them nudged by one, the rest any 20-bit value.
	task automatic send_random_batch(input int unsigned count);
		int unsigned roll;
		int unsigned per_bit;
		logic [BAUD_W-1:0] rate;
		for (int unsigned n = 0; n < count; n++) begin
			roll    = $urandom_range(0, 99);
			per_bit = $urandom_range(3, 17) * $urandom_range(1, 32) * $urandom_range(1, 16);
			rate    = rate_for(per_bit);
			if (roll >= 90)
				rate = BAUD_W'($urandom_range(0, 20'hFFFFF));
			else if (roll >= 75)
				rate = ($urandom_range(0, 1) != 0) ? rate + 1'b1 : rate - 1'b1;
			send_rate(rate);
		end
	endtask

	// Response side: long runs of ready mixed with short and occasional long stalls.
	initial begin
		int unsigned roll;
		int unsigned span;
		bit          level;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			roll = $urandom_range(0, 99);
			if (steady || roll < 60) begin
				level = 1'b1;
				span  = steady ? 1 : $urandom_range(1, 8);
			end else if (roll < 90) begin
				level = 1'b0;
				span  = $urandom_range(1, 3);
			end else begin
				level = 1'b0;
				span  = $urandom_range(20, 80);
			end
			rsp_ch.ready <= level;
			repeat (span) @(posedge clk);
		end
	end

	initial begin
		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.bit_rate <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.data     <= '0;
		clock_setting     = 27'd48_000_000;
		steady            = 1'b0;
		request_count     = 0;
		setting_count     = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Exercise the reset value of the clock register before any write.
		foreach (RESET_CLOCK_RATES[i])
			send_rate(RESET_CLOCK_RATES[i]);
		drain();

		// Zero clock: nothing can match, whatever the rate.
		write_clock('0);
		send_rate(20'd0);
		send_rate(20'd1);
		send_rate(20'hFFFFF);
		drain();

		// Smallest clock: at most one clock per bit, still no match.
		write_clock(27'd1);
		send_rate(20'd1);
		send_rate(20'd0);
		drain();

		// Full-scale register: the top rate still splits, the lowest rate does not.
		write_clock(27'h7FFFFFF);
		send_rate(20'hFFFFF);
		send_rate(20'd1);
		send_rate(rate_for(93));
		send_rate(rate_for(544));
		drain();

		// Random part, one clock setting per batch; run the first batch without idling.
		steady = 1'b1;
		write_clock(27'd100_000_000);
		send_random_batch(20);
		drain();
		steady = 1'b0;

		write_clock(27'd16_000_000);
		send_random_batch(20);
		drain();

		write_clock(CLK_W'($urandom_range(1_000_000, 100_000_000)));
		send_random_batch(20);
		drain();

		write_clock(CLK_W'($urandom_range(1, 100_000_000)));
		send_random_batch(20);
		drain();

		// Allow for anything straggling out of the search after the last result.
		repeat (40) @(posedge clk);

		$display("Sent %0d rate requests across %0d clock register writes and the reset value.",
			request_count, setting_count);
		$display("Checked %0d timing results, %0d of them with an exact divider split.",
			result_count, exact_count);
		if (mismatch_count == 0 && awaited_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Safety net: several times the slowest legal run.
	initial begin
		#100_000_000;
		$display("Timed out with %0d results still awaited.", awaited_count);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
